/* rtl/hsm_pkg.sv */
// ----------------------------------------------------------------------------
// hsm_pkg
// Types and constants shared by the Hall-sensor height mapper modules.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int SAMPLE_W   = 15;
  localparam int HEIGHT_W   = 12;
  localparam int OUT_W      = 16;
  localparam int RES_W      = 4;
  localparam int CNT_W      = 3;
  localparam int ACC_W      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_COEFFS = 6;

  localparam int NUM_REGS   = 8;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int COEF_SEL_W = $clog2(MAX_COEFFS);

  localparam int DIV_W      = SAMPLE_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int PROD_W     = 2 * ACC_W;
  localparam int SPROD_W    = ACC_W + HEIGHT_W + 1;

  localparam logic [REG_IDX_W-1:0] REG_ADC_RES    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COEF_COUNT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_COEF_0     = REG_IDX_W'(2);

  localparam logic [RES_W-1:0] RESET_ADC_RES    = RES_W'(12);
  localparam logic [CNT_W-1:0] RESET_COEF_COUNT = CNT_W'(2);
  localparam logic [ACC_W-1:0] ONE_FIXED        = ACC_W'(1) << FRAC_BITS;

  typedef logic [MAX_COEFFS-1:0][ACC_W-1:0] coef_bank_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_MUL,
    S_ADD,
    S_SCALE,
    S_ROUND
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_fix;
    logic mul;
    logic add;
    logic scale;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/hall_sensor_height_mapper.sv */
// ----------------------------------------------------------------------------
// hall_sensor_height_mapper: Hall-sensor sample to key height, one result per item.
// Accepts one item at a time, only while idle; n = coefficients in use (0..6).
// Flow: a 31-step divider, fix-up, a multiply and an add state per Horner step, scale, round.
// Sync reset clears control and loads register defaults; output register frees the input.
// ----------------------------------------------------------------------------
module hall_sensor_height_mapper
  import hsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     raw_sample,
  input  logic [SAMPLE_W-1:0]     calib_low,
  input  logic [SAMPLE_W-1:0]     calib_high,
  input  logic                    pressed_reads_higher,
  input  logic [HEIGHT_W-1:0]     travel_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] mapped_height
);

  logic [RES_W-1:0] adc_res;
  logic [CNT_W-1:0] coef_count;
  coef_bank_t       coefs;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  hsm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .adc_res    (adc_res),
    .coef_count (coef_count),
    .coefs      (coefs)
  );

  hsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coef_count (coef_count),
    .sts        (sts),
    .cmd        (cmd)
  );

  hsm_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .adc_res              (adc_res),
    .coefs                (coefs),
    .raw_sample           (raw_sample),
    .calib_low            (calib_low),
    .calib_high           (calib_high),
    .pressed_reads_higher (pressed_reads_higher),
    .travel_height        (travel_height),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .mapped_height        (mapped_height)
  );

endmodule

/* rtl/hsm_regs.sv */
// ----------------------------------------------------------------------------
// hsm_regs
// APB register file: ADC resolution, coefficient count and coefficients.
// ----------------------------------------------------------------------------
module hsm_regs
  import hsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output logic [RES_W-1:0]       adc_res,
  output logic [CNT_W-1:0]       coef_count,
  output coef_bank_t             coefs
);

  logic [REG_IDX_W-1:0]  reg_idx;
  logic [COEF_SEL_W-1:0] coef_sel;
  logic                  wr_en;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[ADDR_W-1:2];
  assign coef_sel = COEF_SEL_W'(reg_idx - REG_COEF_0);
  assign wr_en    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_res    <= RESET_ADC_RES;
      coef_count <= RESET_COEF_COUNT;
      coefs      <= {{((MAX_COEFFS-1)*ACC_W){1'b0}}, ONE_FIXED};
    end else if (wr_en) begin
      case (reg_idx)
        REG_ADC_RES:    adc_res    <= pwdata[RES_W-1:0];
        REG_COEF_COUNT: coef_count <= pwdata[CNT_W-1:0];
        default:        coefs[coef_sel] <= pwdata[ACC_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADC_RES:    prdata = DATA_W'(adc_res);
      REG_COEF_COUNT: prdata = DATA_W'(coef_count);
      default:        prdata = coefs[coef_sel];
    endcase
  end

endmodule

/* rtl/hsm_ctrl.sv */
// ----------------------------------------------------------------------------
// hsm_ctrl
// Sequencer: divide, fix-up, Horner steps, scaling and result hand-off.
// ----------------------------------------------------------------------------
module hsm_ctrl
  import hsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CNT_W-1:0] coef_count,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     coef_idx;
  logic [CNT_W-1:0]     coef_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      div_cnt  <= '0;
      coef_idx <= '0;
      coef_num <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: div_cnt <= '0;
        S_DIV:  div_cnt <= div_cnt + DIV_CNT_W'(1);
        S_FIX: begin
          coef_idx <= '0;
          coef_num <= (coef_count > CNT_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS) : coef_count;
        end
        S_ADD:  coef_idx <= coef_idx + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV:   if (div_cnt == DIV_CNT_W'(DIV_W - 1)) state_next = S_FIX;
      S_FIX: begin
        if (coef_count == '0) state_next = S_SCALE;
        else                  state_next = S_MUL;
      end
      S_MUL:   state_next = S_ADD;
      S_ADD: begin
        if ((coef_idx + CNT_W'(1)) == coef_num) state_next = S_SCALE;
        else                                    state_next = S_MUL;
      end
      S_SCALE: state_next = S_ROUND;
      S_ROUND: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_FIX:   cmd.div_fix  = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_ADD:   cmd.add      = 1'b1;
      S_SCALE: cmd.scale    = 1'b1;
      S_ROUND: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/hsm_dp.sv */
// ----------------------------------------------------------------------------
// hsm_dp
// Datapath: restoring divider, inversion, Horner multiply-add, height scaling,
// rounding and the output register.
// ----------------------------------------------------------------------------
module hsm_dp
  import hsm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic [RES_W-1:0]           adc_res,
  input  coef_bank_t                 coefs,
  input  logic [SAMPLE_W-1:0]        raw_sample,
  input  logic [SAMPLE_W-1:0]        calib_low,
  input  logic [SAMPLE_W-1:0]        calib_high,
  input  logic                       pressed_reads_higher,
  input  logic [HEIGHT_W-1:0]        travel_height,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    mapped_height
);

  localparam logic signed [ACC_W+1:0] SAT_MAX33 = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W+1:0] SAT_MIN33 = {3'b111, {(ACC_W-1){1'b0}}};
  localparam logic signed [PROD_W:0]  SAT_MAX65 = {{(PROD_W-ACC_W+2){1'b0}},
                                                   {(ACC_W-1){1'b1}}};
  localparam logic signed [PROD_W:0]  SAT_MIN65 = {{(PROD_W-ACC_W+2){1'b1}},
                                                   {(ACC_W-1){1'b0}}};
  localparam logic [SPROD_W-1:0]      RND_HALF  = SPROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SPROD_W-1:0]      OUT_POS   = SPROD_W'(2 ** (OUT_W - 1) - 1);
  localparam logic [SPROD_W-1:0]      OUT_NEG   = SPROD_W'(2 ** (OUT_W - 1));

  // item registers
  logic [DIV_W-1:0]          quo;
  logic [SAMPLE_W-1:0]       rem;
  logic [SAMPLE_W-1:0]       divisor;
  logic                      q_neg;
  logic                      den_zero;
  logic                      invert;
  logic [HEIGHT_W-1:0]       height;
  coef_bank_t                coef_sr;
  logic signed [ACC_W-1:0]   x;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SPROD_W-1:0] sprod;

  // load
  logic                      bounds_eq;
  logic [SAMPLE_W-1:0]       lo_eff;
  logic [SAMPLE_W-1:0]       hi_eff;
  logic signed [SAMPLE_W:0]  num;
  logic signed [SAMPLE_W:0]  den;
  logic [SAMPLE_W:0]         num_mag;
  logic [SAMPLE_W:0]         den_mag;

  // divide
  logic [SAMPLE_W:0]         rem_sh;
  logic [SAMPLE_W:0]         rem_diff;

  // fix
  logic signed [ACC_W+1:0]   q_s;
  logic signed [ACC_W+1:0]   x_inv;
  logic signed [ACC_W-1:0]   x_fix;

  // Horner add
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [PROD_W:0]    sum;
  logic signed [ACC_W-1:0]   acc_sat;

  // rounding
  logic                      p_neg;
  logic [SPROD_W-1:0]        p_mag;
  logic [SPROD_W-1:0]        p_rnd;
  logic [OUT_W-1:0]          height_sat;

  assign bounds_eq = (calib_low == calib_high);
  assign lo_eff    = bounds_eq ? '0 : calib_low;
  assign hi_eff    = bounds_eq ? SAMPLE_W'((SAMPLE_W+1)'(1) << adc_res) - SAMPLE_W'(1)
                               : calib_high;
  assign num       = $signed({1'b0, raw_sample}) - $signed({1'b0, lo_eff});
  assign den       = $signed({1'b0, hi_eff}) - $signed({1'b0, lo_eff});
  assign num_mag   = num[SAMPLE_W] ? -num : num;
  assign den_mag   = den[SAMPLE_W] ? -den : den;

  assign rem_sh    = {rem, quo[DIV_W-1]};
  assign rem_diff  = rem_sh - {1'b0, divisor};

  assign q_s   = q_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign x_inv = $signed({2'b00, ONE_FIXED}) - (den_zero ? '0 : q_s);

  always_comb begin
    if (!invert) begin
      x_fix = den_zero ? '0 : q_s[ACC_W-1:0];
    end else if (x_inv > SAT_MAX33) begin
      x_fix = SAT_MAX33[ACC_W-1:0];
    end else if (x_inv < SAT_MIN33) begin
      x_fix = SAT_MIN33[ACC_W-1:0];
    end else begin
      x_fix = x_inv[ACC_W-1:0];
    end
  end

  assign prod_sh = prod >>> FRAC_BITS;
  assign sum     = (PROD_W+1)'($signed(coef_sr[0])) + (PROD_W+1)'(prod_sh);

  always_comb begin
    if (sum > SAT_MAX65)      acc_sat = SAT_MAX65[ACC_W-1:0];
    else if (sum < SAT_MIN65) acc_sat = SAT_MIN65[ACC_W-1:0];
    else                      acc_sat = sum[ACC_W-1:0];
  end

  assign p_neg = sprod[SPROD_W-1];
  assign p_mag = p_neg ? SPROD_W'(-sprod) : SPROD_W'(sprod);
  assign p_rnd = (p_mag + RND_HALF) >> FRAC_BITS;

  always_comb begin
    if (p_neg) begin
      if (p_rnd > OUT_NEG) height_sat = OUT_NEG[OUT_W-1:0];
      else                 height_sat = OUT_W'(-p_rnd);
    end else begin
      if (p_rnd > OUT_POS) height_sat = OUT_POS[OUT_W-1:0];
      else                 height_sat = p_rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= {num_mag[SAMPLE_W-1:0], {FRAC_BITS{1'b0}}};
      rem      <= '0;
      divisor  <= den_mag[SAMPLE_W-1:0];
      q_neg    <= num[SAMPLE_W] ^ den[SAMPLE_W];
      den_zero <= (den == '0);
      invert   <= pressed_reads_higher;
      height   <= travel_height;
      coef_sr  <= coefs;
    end
    if (cmd.div_step) begin
      if (!rem_diff[SAMPLE_W]) begin
        rem <= rem_diff[SAMPLE_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SAMPLE_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      x   <= x_fix;
      acc <= '0;
    end
    if (cmd.mul) begin
      prod <= x * acc;
    end
    if (cmd.add) begin
      acc     <= acc_sat;
      coef_sr <= coef_sr >> ACC_W;
    end
    if (cmd.scale) begin
      sprod <= acc * $signed({1'b0, height});
    end
    if (cmd.out_load) begin
      mapped_height <= height_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

/* tb/hall_sensor_height_mapper_test.sv */
// ----------------------------------------------------------------------------
// hall_sensor_height_mapper_test
// Drives raw Hall-sensor samples with calibration bounds, invert flag and
// travel height into the mapper, and checks every mapped height against
// a typed value or a fixed-point model of normalize, invert, Horner
// polynomial and scaling. A short table of directed samples covers the
// bound extremes, the equal-bounds and zero-divisor fallbacks, an
// oversized and an empty coefficient count, and saturation at both ends.
// Random phases follow, each with its own coefficient set, under several
// patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hall_sensor_height_mapper_test;
  import hsm_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 8;
  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int DRAIN_CYCLES    = 60;
  localparam int NUM_ROWS        = 23;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
    logic                invert;
    logic [HEIGHT_W-1:0] height;
  } sample_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [CNT_W-1:0] count;
    coef_bank_t       coefs;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              setting;
    sample_t                 stim;
    logic                    typed;
    logic signed [OUT_W-1:0] want;
  } row_t;

  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{3'd0, '{15'd100,   15'd100,   15'd3000,  1'b0, 12'd4095}, 1'b1, 16'sd0},
    '{3'd0, '{15'd3000,  15'd100,   15'd3000,  1'b0, 12'd4095}, 1'b1, 16'sd4095},
    '{3'd0, '{15'd0,     15'd500,   15'd500,   1'b0, 12'd4095}, 1'b1, 16'sd0},
    '{3'd0, '{15'd4095,  15'd7,     15'd7,     1'b0, 12'd1234}, 1'b1, 16'sd1234},
    '{3'd0, '{15'd32767, 15'd0,     15'd1,     1'b0, 12'd4095}, 1'b1, 16'sd32767},
    '{3'd0, '{15'd0,     15'd32766, 15'd32767, 1'b0, 12'd4095}, 1'b1, 16'sh8000},
    '{3'd0, '{15'd0,     15'd32767, 15'd32766, 1'b0, 12'd4095}, 1'b1, 16'sd32767},
    '{3'd0, '{15'd200,   15'd200,   15'd1200,  1'b1, 12'd4095}, 1'b1, 16'sd4095},
    '{3'd0, '{15'd1200,  15'd200,   15'd1200,  1'b1, 12'd4095}, 1'b1, 16'sd0},
    '{3'd0, '{15'd700,   15'd200,   15'd1200,  1'b0, 12'd0},    1'b1, 16'sd0},
    '{3'd0, '{15'd12345, 15'd1111,  15'd30000, 1'b1, 12'd2047}, 1'b0, 16'sd0},
    '{3'd0, '{15'd32767, 15'd32767, 15'd32767, 1'b0, 12'd4095}, 1'b0, 16'sd0},
    '{3'd0, '{15'd1,     15'd30000, 15'd2,     1'b0, 12'd3000}, 1'b0, 16'sd0},
    '{3'd1, '{15'd5,     15'd9,     15'd9,     1'b0, 12'd100},  1'b1, 16'sd300},
    '{3'd1, '{15'd32767, 15'd0,     15'd0,     1'b1, 12'd1000}, 1'b0, 16'sd0},
    '{3'd1, '{15'd10,    15'd0,     15'd20,    1'b0, 12'd4095}, 1'b0, 16'sd0},
    '{3'd2, '{15'd32767, 15'd0,     15'd32767, 1'b0, 12'd4095}, 1'b1, 16'sd0},
    '{3'd2, '{15'd0,     15'd3,     15'd3,     1'b1, 12'd4095}, 1'b1, 16'sd0},
    '{3'd3, '{15'd1,     15'd0,     15'd0,     1'b0, 12'd4095}, 1'b0, 16'sd0},
    '{3'd3, '{15'd32767, 15'd0,     15'd1,     1'b0, 12'd4095}, 1'b0, 16'sd0},
    '{3'd3, '{15'd0,     15'd32767, 15'd0,     1'b1, 12'd4095}, 1'b0, 16'sd0},
    '{3'd4, '{15'd32767, 15'd5,     15'd5,     1'b0, 12'd4095}, 1'b1, -16'sd4095},
    '{3'd4, '{15'd100,   15'd0,     15'd200,   1'b0, 12'd1},    1'b1, -16'sd1}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     raw_sample = '0;
  logic [SAMPLE_W-1:0]     calib_low = '0;
  logic [SAMPLE_W-1:0]     calib_high = '0;
  logic                    pressed_reads_higher = 1'b0;
  logic [HEIGHT_W-1:0]     travel_height = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] mapped_height;

  logic signed [OUT_W-1:0] pending_heights [$];
  logic signed [OUT_W-1:0] oldest_height;
  cfg_t                    active_cfg;
  cfg_t                    directed_cfgs [5];
  int                      send_gap_pct = 0;
  int                      recv_stall_pct = 0;
  int                      hold_off_left = 0;
  int                      mismatch_count = 0;
  int                      quiet_cycles = 0;
  int                      current_setting;

  hall_sensor_height_mapper uut (
    .clk                  (clk),
    .rst                  (rst),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .raw_sample           (raw_sample),
    .calib_low            (calib_low),
    .calib_high           (calib_high),
    .pressed_reads_higher (pressed_reads_higher),
    .travel_height        (travel_height),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .mapped_height        (mapped_height)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_height(input sample_t s, input cfg_t c);
    longint lo, hi, num, den, x, acc, p, mag, q;
    int     n;
    lo = longint'(s.low);
    hi = longint'(s.high);
    if (lo == hi) begin
      lo = 0;
      hi = (longint'(1) << c.res) - 1;
    end
    num = longint'(s.raw) - lo;
    den = hi - lo;
    x = (den == 0) ? 0 : clamp32((num * (longint'(1) << FRAC_BITS)) / den);
    if (s.invert) x = clamp32((longint'(1) << FRAC_BITS) - x);
    n = (int'(c.count) > MAX_COEFFS) ? MAX_COEFFS : int'(c.count);
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc = clamp32(longint'($signed(c.coefs[i])) + ((x * acc) >>> FRAC_BITS));
    end
    p = acc * longint'(s.height);
    mag = (p < 0) ? -p : p;
    mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    q = (p < 0) ? -mag : mag;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return OUT_W'(q);
  endfunction

  function automatic cfg_t make_cfg(input int res, input int count,
                                    input logic [ACC_W-1:0] c0, input logic [ACC_W-1:0] c1,
                                    input logic [ACC_W-1:0] c2, input logic [ACC_W-1:0] c3,
                                    input logic [ACC_W-1:0] c4, input logic [ACC_W-1:0] c5);
    cfg_t c;
    c.res = RES_W'(res);
    c.count = CNT_W'(count);
    c.coefs[0] = c0;
    c.coefs[1] = c1;
    c.coefs[2] = c2;
    c.coefs[3] = c3;
    c.coefs[4] = c4;
    c.coefs[5] = c5;
    return c;
  endfunction

  function automatic logic [ACC_W-1:0] random_coef();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return ACC_W'($urandom_range(32'h80000, 0)) - ACC_W'(32'h40000);
    if (pick < 85) return ACC_W'($urandom_range(32'h20000, 0)) - ACC_W'(32'h10000);
    return ACC_W'($urandom());
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.res = RES_W'(($urandom_range(99, 0) < 70) ? $urandom_range(15, 8) : $urandom_range(7, 0));
    c.count = CNT_W'($urandom_range(7, 0));
    for (int i = 0; i < MAX_COEFFS; i++) c.coefs[i] = random_coef();
    return c;
  endfunction

  function automatic sample_t random_sample(input cfg_t c);
    sample_t s;
    int      full_scale, span, a, b, pick;
    full_scale = (1 << c.res) - 1;
    s.raw = SAMPLE_W'($urandom_range(32767, 0));
    s.low = SAMPLE_W'($urandom_range(32767, 0));
    s.high = SAMPLE_W'($urandom_range(32767, 0));
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      s.high = s.low;
      if ($urandom_range(3, 0) != 0) s.raw = SAMPLE_W'($urandom_range(full_scale, 0));
    end else if (pick < 85) begin
      span = $urandom_range(1, 0) ? full_scale : 32767;
      a = $urandom_range(span, 0);
      b = $urandom_range(span, 0);
      s.low = SAMPLE_W'(a);
      s.high = SAMPLE_W'(b);
      if ($urandom_range(9, 0) != 0) s.raw = SAMPLE_W'($urandom_range(a, b));
    end
    s.invert = 1'($urandom_range(1, 0));
    pick = $urandom_range(19, 0);
    if (pick == 0) s.height = '0;
    else if (pick == 1) s.height = '1;
    else s.height = HEIGHT_W'($urandom_range(4095, 0));
    return s;
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_settings(input cfg_t c);
    apb_write(REG_ADC_RES, DATA_W'(c.res));
    apb_write(REG_COEF_COUNT, DATA_W'(c.count));
    for (int i = 0; i < MAX_COEFFS; i++) begin
      apb_write(REG_COEF_0 + REG_IDX_W'(i), c.coefs[i]);
    end
    active_cfg = c;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input logic signed [OUT_W-1:0] want);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= s.raw;
    calib_low <= s.low;
    calib_high <= s.high;
    pressed_reads_higher <= s.invert;
    travel_height <= s.height;
    do @(posedge clk); while (!in_ready);
    pending_heights.push_back(want);
  endtask

  // sink side: long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ready <= !($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_heights.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected transaction: mapped_height %0d", mapped_height);
        mismatch_count++;
      end else begin
        oldest_height = pending_heights.pop_front();
        if (mapped_height !== oldest_height) begin
          if (mismatch_count < 10) begin
            $display("mapped_height mismatch: expected %0d, got %0d", oldest_height, mapped_height);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    active_cfg = make_cfg(int'(RESET_ADC_RES), int'(RESET_COEF_COUNT), ONE_FIXED, 0, 0, 0, 0, 0);
    directed_cfgs[0] = active_cfg;
    directed_cfgs[1] = make_cfg(0, 7, 32'h0001_0000, 32'hfffe_0000, 32'h0, 32'h0000_8000,
                                32'h0, 32'h0003_0000);
    directed_cfgs[2] = make_cfg(15, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    directed_cfgs[3] = make_cfg(1, 6, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    directed_cfgs[4] = make_cfg(15, 1, 32'hffff_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    current_setting = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (int'(DIRECTED_ROWS[r].setting) != current_setting) begin
        drain_results();
        current_setting = int'(DIRECTED_ROWS[r].setting);
        write_settings(directed_cfgs[current_setting]);
      end
      send_sample(DIRECTED_ROWS[r].stim,
                  DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want
                                         : predict_height(DIRECTED_ROWS[r].stim, active_cfg));
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      write_settings(random_cfg());
      // no gaps / sparse source / stalling sink / both lightly
      case (phase % 4)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_gap_pct = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (phase == 0) begin
        @(posedge clk);
        hold_off_left = HOLD_OFF_CYCLES;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sample_t s;
        if (phase == 2 && k == ITEMS_PER_PHASE / 2) drain_results();
        s = random_sample(active_cfg);
        send_sample(s, predict_height(s, active_cfg));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_heights.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
